// ===== rtl/core/base64_codec_defines.svh =====
// ----------------------------------------------------------------------------
// Base64 codec assertion macros
// Shared assertion forms for the checkers of the codec. Each one expects
// clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BASE64_CODEC_DEFINES_SVH
`define BASE64_CODEC_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define B64_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define B64_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/b64_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 codec package
// Types, codes and alphabet functions shared by the codec modules.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_PAD  = 2'd2;
    localparam logic [1:0] ST_BAD_BITS = 2'd3;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;
    localparam logic [1:0] PHASE_3 = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last_result;
        logic [1:0] status;
    } item_t;

    // All results caused by one input beat; slot 0 goes out first.
    typedef struct packed {
        logic [1:0]      last_idx;
        item_t [3:0]     items;
    } bundle_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)      return w + 8'd65;
        else if (v < 6'd52) return w + 8'd71;
        else if (v < 6'd62) return w + 8'd252;
        else if (v == 6'd62) return 8'h2B;
        else                return 8'h2F;
    endfunction

    // Bit 6 set means the character is not in the alphabet.
    function automatic logic [6:0] dec_sextet(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'd0;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            d = ch - 8'h41;
            return {1'b0, d[5:0]};
        end
        else if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            d = ch - 8'h47;
            return {1'b0, d[5:0]};
        end
        else if (ch >= 8'h30 && ch <= 8'h39)
        begin
            d = ch + 8'h04;
            return {1'b0, d[5:0]};
        end
        else if (ch == 8'h2B) return 7'd62;
        else if (ch == 8'h2F) return 7'd63;
        else                  return 7'h40;
    endfunction

endpackage

// ===== rtl/core/base64_codec.sv =====
// A result goes through the bundle queue and then the output register on its way out.
// Throughput: one input beat per cycle while each beat causes at most one result and the
// sink is ready; the output register sends one result a cycle, slot by slot, while ready.
// Encoding averages four results per three bytes, plus up to three more on the last byte.
// Reset: asynchronous and active low; it selects encode mode and clears all message state.
// ----------------------------------------------------------------------------
// Base64 codec top level
// Streaming base64 encoder and decoder with a mode register.
// ----------------------------------------------------------------------------
module base64_codec
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [2:0] m_tuser,   // is_data, status[1:0]
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic             push;
    logic             queue_full;
    logic             pop;
    logic             head_valid;
    b64_pkg::bundle_t push_bundle;
    b64_pkg::bundle_t head_bundle;

    assign cfg_ready = 1'b1;

    b64_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .push        (push),
        .push_bundle (push_bundle),
        .queue_full  (queue_full)
    );

    b64_queue u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (queue_full),
        .pop         (pop),
        .head_valid  (head_valid),
        .head_bundle (head_bundle)
    );

    b64_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_bundle (head_bundle),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== rtl/core/b64_front.sv =====
// ----------------------------------------------------------------------------
// Base64 codec front end
// Accepts input beats, runs the encode or decode state and turns each beat
// that causes results into a bundle of up to four results for the back end.
// ----------------------------------------------------------------------------
module b64_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // in_byte
    input  logic            s_tlast,
    input  logic            cfg_valid,
    input  logic            cfg_data,
    output logic            push,
    output b64_pkg::bundle_t push_bundle,
    input  logic            queue_full
);

    logic       mode_reg,    mode_next;
    logic [1:0] phase_reg,   phase_next;
    logic [7:0] carry_reg,   carry_next;
    logic [3:0] low_reg,     low_next;
    logic       stopped_reg, stopped_next;
    logic [1:0] pads_reg,    pads_next;
    logic       extra_reg,   extra_next;
    logic [1:0] err_reg,     err_next;
    logic [2:0] n;
    logic [2:0] n_m1;
    logic [6:0] sext;
    logic [1:0] st;
    logic       accept;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign sext     = b64_pkg::dec_sextet(s_tdata);

    always_comb
    begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        carry_next   = carry_reg;
        low_next     = low_reg;
        stopped_next = stopped_reg;
        pads_next    = pads_reg;
        extra_next   = extra_reg;
        err_next     = err_reg;
        push_bundle  = '0;
        n            = 3'd0;
        n_m1         = 3'd0;
        st           = b64_pkg::ST_OK;
        if (!mode_reg)
        begin
            unique case (phase_reg)
                b64_pkg::PHASE_0:
                begin
                    push_bundle.items[0].out_byte = b64_pkg::enc_char(s_tdata[7:2]);
                    carry_next = {2'b00, s_tdata[1:0], 4'b0000};
                    phase_next = b64_pkg::PHASE_1;
                    n = 3'd1;
                end
                b64_pkg::PHASE_1:
                begin
                    push_bundle.items[0].out_byte =
                        b64_pkg::enc_char({carry_reg[5:4], s_tdata[7:4]});
                    carry_next = {2'b00, s_tdata[3:0], 2'b00};
                    phase_next = b64_pkg::PHASE_2;
                    n = 3'd1;
                end
                default:
                begin
                    push_bundle.items[0].out_byte =
                        b64_pkg::enc_char({carry_reg[5:2], s_tdata[7:6]});
                    push_bundle.items[1].out_byte = b64_pkg::enc_char(s_tdata[5:0]);
                    carry_next = 8'd0;
                    phase_next = b64_pkg::PHASE_0;
                    n = 3'd2;
                end
            endcase
            push_bundle.items[0].is_data = 1'b1;
            push_bundle.items[1].is_data = 1'b1;
            push_bundle.items[2].is_data = 1'b1;
            push_bundle.items[3].is_data = 1'b1;
            if (s_tlast)
            begin
                if (phase_next != b64_pkg::PHASE_0)
                begin
                    push_bundle.items[1].out_byte = b64_pkg::enc_char(carry_next[5:0]);
                    push_bundle.items[2].out_byte = b64_pkg::PAD_CHAR;
                    push_bundle.items[3].out_byte = b64_pkg::PAD_CHAR;
                    n = (phase_next == b64_pkg::PHASE_1) ? 3'd4 : 3'd3;
                end
                n_m1 = n - 3'd1;
                push_bundle.items[n_m1[1:0]].last_result = 1'b1;
            end
        end
        else
        begin
            if (err_reg != b64_pkg::ST_OK)
            begin
                n = 3'd0;
            end
            else if (stopped_reg)
            begin
                if (s_tdata == b64_pkg::PAD_CHAR)
                begin
                    if (pads_reg != 2'd3) pads_next = pads_reg + 2'd1;
                end
                else
                begin
                    extra_next = 1'b1;
                end
            end
            else if (s_tdata == b64_pkg::PAD_CHAR)
            begin
                stopped_next = 1'b1;
                pads_next    = 2'd1;
            end
            else if (sext[6])
            begin
                err_next = b64_pkg::ST_BAD_CHAR;
            end
            else
            begin
                unique case (phase_reg)
                    b64_pkg::PHASE_0:
                    begin
                        carry_next = {sext[5:0], 2'b00};
                        phase_next = b64_pkg::PHASE_1;
                    end
                    b64_pkg::PHASE_1:
                    begin
                        push_bundle.items[0].out_byte = carry_reg | {6'd0, sext[5:4]};
                        carry_next = {sext[3:0], 4'b0000};
                        phase_next = b64_pkg::PHASE_2;
                        n = 3'd1;
                    end
                    b64_pkg::PHASE_2:
                    begin
                        push_bundle.items[0].out_byte = carry_reg | {4'd0, sext[5:2]};
                        carry_next = {sext[1:0], 6'd0};
                        phase_next = b64_pkg::PHASE_3;
                        n = 3'd1;
                    end
                    default:
                    begin
                        push_bundle.items[0].out_byte = carry_reg | {2'd0, sext[5:0]};
                        phase_next = b64_pkg::PHASE_0;
                        n = 3'd1;
                    end
                endcase
                push_bundle.items[0].is_data = 1'b1;
                low_next = sext[3:0];
            end
            if (s_tlast)
            begin
                st = err_next;
                if (st == b64_pkg::ST_OK)
                begin
                    unique case (phase_next)
                        b64_pkg::PHASE_1: st = b64_pkg::ST_BAD_BITS;
                        b64_pkg::PHASE_2:
                        begin
                            if (low_next != 4'd0) st = b64_pkg::ST_BAD_BITS;
                            else if (!(stopped_next && pads_next == 2'd2 && !extra_next))
                                st = b64_pkg::ST_BAD_PAD;
                        end
                        b64_pkg::PHASE_3:
                        begin
                            if (low_next[1:0] != 2'd0) st = b64_pkg::ST_BAD_BITS;
                            else if (!(stopped_next && pads_next == 2'd1 && !extra_next))
                                st = b64_pkg::ST_BAD_PAD;
                        end
                        default: st = b64_pkg::ST_OK;
                    endcase
                end
                push_bundle.items[n[1:0]].out_byte    = 8'd0;
                push_bundle.items[n[1:0]].is_data     = 1'b0;
                push_bundle.items[n[1:0]].last_result = 1'b1;
                push_bundle.items[n[1:0]].status      = st;
                n = n + 3'd1;
            end
        end
        n_m1 = n - 3'd1;
        push_bundle.last_idx = n_m1[1:0];
        if (s_tlast)
        begin
            phase_next   = b64_pkg::PHASE_0;
            carry_next   = 8'd0;
            low_next     = 4'd0;
            stopped_next = 1'b0;
            pads_next    = 2'd0;
            extra_next   = 1'b0;
            err_next     = b64_pkg::ST_OK;
        end
    end

    assign push = accept && (n != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            phase_reg   <= b64_pkg::PHASE_0;
            carry_reg   <= 8'd0;
            low_reg     <= 4'd0;
            stopped_reg <= 1'b0;
            pads_reg    <= 2'd0;
            extra_reg   <= 1'b0;
            err_reg     <= b64_pkg::ST_OK;
        end
        else if (cfg_valid)
        begin
            mode_reg    <= cfg_data;
            phase_reg   <= b64_pkg::PHASE_0;
            carry_reg   <= 8'd0;
            low_reg     <= 4'd0;
            stopped_reg <= 1'b0;
            pads_reg    <= 2'd0;
            extra_reg   <= 1'b0;
            err_reg     <= b64_pkg::ST_OK;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            carry_reg   <= carry_next;
            low_reg     <= low_next;
            stopped_reg <= stopped_next;
            pads_reg    <= pads_next;
            extra_reg   <= extra_next;
            err_reg     <= err_next;
        end
    end

endmodule

// ===== rtl/core/b64_queue.sv =====
// ----------------------------------------------------------------------------
// Base64 codec bundle queue
// Two-entry queue of result bundles between the front end and the back end.
// ----------------------------------------------------------------------------
module b64_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64_pkg::bundle_t push_bundle,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output b64_pkg::bundle_t head_bundle
);

    b64_pkg::bundle_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_push;
    logic       do_pop;

    assign full        = (count_reg == 2'd2);
    assign head_valid  = (count_reg != 2'd0);
    assign head_bundle = entry_reg[rd_ptr_reg];
    assign do_push     = push && !full;
    assign do_pop      = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_bundle;
        end
    end

endmodule

// ===== rtl/core/b64_back.sv =====
// ----------------------------------------------------------------------------
// Base64 codec back end
// Sends the results of the head bundle out one beat at a time through an
// output register.
// ----------------------------------------------------------------------------
module b64_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  b64_pkg::bundle_t head_bundle,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic [2:0]       m_tuser,   // is_data, status[1:0]
    output logic             m_tlast
);

    b64_pkg::item_t out_reg;
    logic           valid_reg, valid_next;
    logic [1:0]     idx_reg,   idx_next;
    logic           load;

    assign load = head_valid && (!valid_reg || m_tready);
    assign pop  = load && (idx_reg == head_bundle.last_idx);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = pop ? 2'd0 : idx_reg + 2'd1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= head_bundle.items[idx_reg];
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tuser  = {out_reg.status, out_reg.is_data};
    assign m_tlast  = out_reg.last_result;

endmodule

// ===== rtl/core/b64_checker.sv =====
// ----------------------------------------------------------------------------
// Base64 codec port checker
// Checks the result stream seen at the ports of the codec.
// ----------------------------------------------------------------------------
`include "base64_codec_defines.svh"

module b64_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    `B64_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `B64_ASSERT_SAME(a_data_ok, m_tvalid && m_tuser[0], m_tuser[2:1] == 2'd0)
    `B64_ASSERT_SAME(a_status_last, m_tvalid && !m_tuser[0], m_tlast && m_tdata == 8'd0)

endmodule

bind base64_codec b64_checker u_b64_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base64 codec regression bench
// Drives byte and character messages into the codec in both modes, predicts
// every output beat with an independent encoder and decoder, and checks the
// output stream beat by beat under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import b64_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [8*64-1:0] ALPHABET_BITS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;    // in_byte
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // out_byte
    logic [2:0] m_tuser;            // is_data, status[1:0]
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    item_t      pending_results[$];
    logic [7:0] msg_text[$];
    int         mismatches = 0;
    int         beats_sent = 0;
    int         cycle_count = 0;
    bit         tx_idle_on = 1'b1;
    bit         rx_idle_on = 1'b1;
    int         hold_len = 0;
    int         hold_req = 0;

    logic       codec_mode = MODE_ENCODE;
    logic [1:0] msg_phase = PHASE_0;
    logic [7:0] msg_carry = 8'h00;
    logic [3:0] msg_low4 = 4'h0;
    logic       msg_stopped = 1'b0;
    logic [1:0] msg_pads = 2'd0;
    logic       msg_extra = 1'b0;
    logic [1:0] msg_error = ST_OK;

    base64_codec dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return ALPHABET_BITS[8 * (63 - int'(v)) +: 8];
    endfunction

    function automatic int sextet_index(input logic [7:0] ch);
        for (int i = 0; i < 64; i++)
        begin
            if (sextet_char(i[5:0]) == ch)
                return i;
        end
        return -1;
    endfunction

    function automatic item_t data_item(input logic [7:0] value);
        item_t r;
        r.out_byte = value;
        r.is_data = 1'b1;
        r.last_result = 1'b0;
        r.status = ST_OK;
        return r;
    endfunction

    task automatic clear_message_state();
        msg_phase = PHASE_0;
        msg_carry = 8'h00;
        msg_low4 = 4'h0;
        msg_stopped = 1'b0;
        msg_pads = 2'd0;
        msg_extra = 1'b0;
        msg_error = ST_OK;
    endtask

    task automatic predict_encoded_chars(input logic [7:0] b, input logic last);
        item_t burst[4];
        int    n;
        n = 0;
        case (msg_phase)
            PHASE_0:
            begin
                burst[n] = data_item(sextet_char(b[7:2]));
                n++;
                msg_carry = {2'b00, b[1:0], 4'b0000};
                msg_phase = PHASE_1;
            end
            PHASE_1:
            begin
                burst[n] = data_item(sextet_char(msg_carry[5:0] | {2'b00, b[7:4]}));
                n++;
                msg_carry = {2'b00, b[3:0], 2'b00};
                msg_phase = PHASE_2;
            end
            default:
            begin
                burst[n] = data_item(sextet_char(msg_carry[5:0] | {4'b0000, b[7:6]}));
                n++;
                burst[n] = data_item(sextet_char(b[5:0]));
                n++;
                msg_carry = 8'h00;
                msg_phase = PHASE_0;
            end
        endcase
        if (last)
        begin
            if (msg_phase != PHASE_0)
            begin
                burst[n] = data_item(sextet_char(msg_carry[5:0]));
                n++;
                burst[n] = data_item(PAD_CHAR);
                n++;
                if (msg_phase == PHASE_1)
                begin
                    burst[n] = data_item(PAD_CHAR);
                    n++;
                end
            end
            burst[n - 1].last_result = 1'b1;
            clear_message_state();
        end
        for (int i = 0; i < n; i++)
            pending_results.push_back(burst[i]);
    endtask

    task automatic predict_decoded_bytes(input logic [7:0] ch, input logic last);
        int         idx;
        logic [5:0] d;
        item_t      r;
        idx = sextet_index(ch);
        if (msg_error == ST_OK)
        begin
            if (msg_stopped)
            begin
                if (ch == PAD_CHAR)
                begin
                    if (msg_pads != 2'd3)
                        msg_pads = msg_pads + 2'd1;
                end
                else
                    msg_extra = 1'b1;
            end
            else if (ch == PAD_CHAR)
            begin
                msg_stopped = 1'b1;
                msg_pads = 2'd1;
            end
            else if (idx < 0)
                msg_error = ST_BAD_CHAR;
            else
            begin
                d = idx[5:0];
                case (msg_phase)
                    PHASE_0:
                    begin
                        msg_carry = {d, 2'b00};
                        msg_phase = PHASE_1;
                    end
                    PHASE_1:
                    begin
                        pending_results.push_back(data_item(msg_carry | {6'b0, d[5:4]}));
                        msg_carry = {d[3:0], 4'b0000};
                        msg_phase = PHASE_2;
                    end
                    PHASE_2:
                    begin
                        pending_results.push_back(data_item(msg_carry | {4'b0, d[5:2]}));
                        msg_carry = {d[1:0], 6'b000000};
                        msg_phase = PHASE_3;
                    end
                    default:
                    begin
                        pending_results.push_back(data_item(msg_carry | {2'b0, d}));
                        msg_phase = PHASE_0;
                    end
                endcase
                msg_low4 = d[3:0];
            end
        end
        if (last)
        begin
            r.out_byte = 8'h00;
            r.is_data = 1'b0;
            r.last_result = 1'b1;
            r.status = msg_error;
            if (msg_error == ST_OK)
            begin
                if (msg_phase == PHASE_1)
                    r.status = ST_BAD_BITS;
                else if (msg_phase == PHASE_2)
                begin
                    if (msg_low4 != 4'h0)
                        r.status = ST_BAD_BITS;
                    else if (!(msg_stopped && msg_pads == 2'd2 && !msg_extra))
                        r.status = ST_BAD_PAD;
                end
                else if (msg_phase == PHASE_3)
                begin
                    if (msg_low4[1:0] != 2'b00)
                        r.status = ST_BAD_BITS;
                    else if (!(msg_stopped && msg_pads == 2'd1 && !msg_extra))
                        r.status = ST_BAD_PAD;
                end
            end
            pending_results.push_back(r);
            clear_message_state();
        end
    endtask

    task automatic send_symbol(input logic [7:0] value, input logic last);
        while (tx_idle_on && $urandom_range(0, 99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tlast <= last;
        if (codec_mode == MODE_DECODE)
            predict_decoded_bytes(value, last);
        else
            predict_encoded_chars(value, last);
        beats_sent++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_message(input bit is_last = 1'b1);
        for (int i = 0; i < msg_text.size(); i++)
            send_symbol(msg_text[i], is_last && (i == msg_text.size() - 1));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        codec_mode = mode;
        clear_message_state();
    endtask

    task automatic build_base64_text(input int n_bytes);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        int         rem;
        msg_text = {};
        for (int i = 0; i < n_bytes; i += 3)
        begin
            b0 = 8'($urandom_range(0, 255));
            b1 = 8'($urandom_range(0, 255));
            b2 = 8'($urandom_range(0, 255));
            rem = n_bytes - i;
            msg_text.push_back(sextet_char(b0[7:2]));
            if (rem == 1)
            begin
                msg_text.push_back(sextet_char({b0[1:0], 4'b0000}));
                msg_text.push_back(PAD_CHAR);
                msg_text.push_back(PAD_CHAR);
            end
            else if (rem == 2)
            begin
                msg_text.push_back(sextet_char({b0[1:0], b1[7:4]}));
                msg_text.push_back(sextet_char({b1[3:0], 2'b00}));
                msg_text.push_back(PAD_CHAR);
            end
            else
            begin
                msg_text.push_back(sextet_char({b0[1:0], b1[7:4]}));
                msg_text.push_back(sextet_char({b1[3:0], b2[7:6]}));
                msg_text.push_back(sextet_char(b2[5:0]));
            end
        end
    endtask

    task automatic damage_text();
        int pick;
        int pos;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return;
        pos = $urandom_range(0, msg_text.size() - 1);
        if (pick < 78)
            msg_text[pos] = 8'($urandom_range(0, 255));
        else if (pick < 84 && msg_text.size() > 1)
            void'(msg_text.pop_back());
        else if (pick < 90)
        begin
            case ($urandom_range(0, 2))
                0: msg_text.push_back(PAD_CHAR);
                1: msg_text.push_back(sextet_char(6'($urandom_range(0, 63))));
                default: msg_text.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        else if (pick < 95)
        begin
            while (msg_text.size() > 1 && msg_text[msg_text.size() - 1] == PAD_CHAR)
                void'(msg_text.pop_back());
        end
        else
        begin
            msg_text = {};
            repeat ($urandom_range(1, 6))
                msg_text.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_bytes(input int n);
        msg_text = {};
        repeat (n)
            msg_text.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic note_failure(input string what, input item_t want, input item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected byte %h data %b last %b status %0d, got byte %h data %b last %b status %0d",
                     what, want.out_byte, want.is_data, want.last_result, want.status,
                     got.out_byte, got.is_data, got.last_result, got.status);
    endtask

    task automatic check_result();
        item_t want;
        item_t got;
        got.out_byte = m_tdata;
        got.is_data = m_tuser[0];
        got.status = m_tuser[2:1];
        got.last_result = m_tlast;
        if (pending_results.size() == 0)
            note_failure("unexpected beat", got, got);
        else
        begin
            want = pending_results.pop_front();
            if (got !== want)
                note_failure("mismatch", want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
    end

    initial
    begin : sink_stall
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(rx_idle_on && $urandom_range(0, 99) < 32);
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("base64_codec regression: fail");
        $finish;
    end

    task automatic test_encode_directed();
        write_mode(MODE_ENCODE);
        msg_text = {8'h00};
        send_message();
        msg_text = {8'hFF, 8'hFF};
        send_message();
        msg_text = {8'h00, 8'hFF, 8'h80};
        send_message();
        wait_drained();
    endtask

    task automatic test_decode_directed();
        write_mode(MODE_DECODE);
        msg_text = {"a", "z", "0", PAD_CHAR};
        send_message();
        msg_text = {"T", "Q", PAD_CHAR, PAD_CHAR};
        send_message();
        msg_text = {"Z", "/"};
        send_message();
        msg_text = {"A"};
        send_message();
        msg_text = {"A", 8'h00, 8'hFF};
        send_message();
        msg_text = {PAD_CHAR, "+"};
        send_message();
        msg_text = {"A", "A", PAD_CHAR};
        send_message();
        wait_drained();
    endtask

    task automatic test_mode_rewrite_clears();
        write_mode(MODE_DECODE);
        msg_text = {"T", "W"};
        send_message(1'b0);
        write_mode(MODE_DECODE);
        msg_text = {"T", "Q", PAD_CHAR, PAD_CHAR};
        send_message();
        write_mode(MODE_ENCODE);
        msg_text = {8'h41};
        send_message(1'b0);
        write_mode(MODE_ENCODE);
        msg_text = {8'hFF};
        send_message();
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_mode(MODE_ENCODE);
        tx_idle_on = 1'b0;
        hold_len = 300;
        hold_req++;
        random_bytes(40);
        send_message();
        wait_drained();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_encode();
        int target;
        write_mode(MODE_ENCODE);
        target = beats_sent + 120;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (beats_sent < target)
        begin
            if (beats_sent > target - 70)
            begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
            random_bytes($urandom_range(1, 9));
            send_message();
        end
        wait_drained();
    endtask

    task automatic test_random_decode();
        int target;
        write_mode(MODE_DECODE);
        target = beats_sent + 170;
        while (beats_sent < target)
        begin
            build_base64_text($urandom_range(1, 7));
            damage_text();
            send_message();
        end
        wait_drained();
    endtask

    task automatic test_random_mixed();
        int   target;
        logic mode;
        target = beats_sent + 60;
        while (beats_sent < target)
        begin
            mode = 1'($urandom_range(0, 1));
            if (mode != codec_mode || $urandom_range(0, 3) == 0)
                write_mode(mode);
            if (mode == MODE_DECODE)
            begin
                build_base64_text($urandom_range(1, 5));
                damage_text();
            end
            else
                random_bytes($urandom_range(1, 6));
            send_message();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_encode_directed();
        test_decode_directed();
        test_mode_rewrite_clears();
        test_backpressure();
        test_random_encode();
        test_random_decode();
        test_random_mixed();
        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("base64_codec regression: pass");
        else
            $display("base64_codec regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/b64_pkg.sv
rtl/core/b64_front.sv
rtl/core/b64_queue.sv
rtl/core/b64_back.sv
rtl/core/base64_codec.sv
rtl/core/b64_checker.sv
tb/sv/tb_top.sv
